[hdl/sijb_pkg.sv]
// Package for the sequenced input jitter buffer: widths, command and register
// codes, reset values, the ring record type and the controller state type.
// No dependencies.
`default_nettype none

package sijb_pkg;

    localparam int RING_DEPTH   = 64;
    localparam int PAYLOAD_BITS = 32;

    localparam int PTR_W      = $clog2(RING_DEPTH);
    localparam int CNT_W      = $clog2(RING_DEPTH + 1);
    localparam int SEQ_W      = 8;
    localparam int CMD_W      = 2;
    localparam int DELAY_W    = 24;
    localparam int MAXOCC_W   = 6;
    localparam int LINK_W     = 20;
    localparam int TICK_W     = 17;
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;
    localparam int STEP_W     = 8;

    localparam logic [CMD_W-1:0] CMD_ENQUEUE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_TICK    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_FLUSH   = 2'd2;

    localparam logic [1:0] REG_MAX_OCC   = 2'd0;
    localparam logic [1:0] REG_LINK_DLY  = 2'd1;
    localparam logic [1:0] REG_TICK_PER  = 2'd2;

    localparam logic [MAXOCC_W-1:0] MAXOCC_RESET = 6'd16;
    localparam logic [LINK_W-1:0]   LINK_RESET   = 20'd0;
    localparam logic [TICK_W-1:0]   TICK_RESET   = 17'd16667;
    localparam logic [DELAY_W-1:0]  DELAY_RESET  = 24'd200000;
    localparam logic [DELAY_W-1:0]  DELAY_MAX    = 24'hFFFFFF;
    localparam logic [STEP_W-1:0]   STEP_MAX     = 8'd255;

    localparam logic [9:0]  ALPHA_NUM  = 10'd655;
    localparam logic [15:0] ALPHA_KEEP = 16'd64881;
    localparam logic [15:0] ROUND_HALF = 16'd32768;

    typedef struct packed {
        logic [SEQ_W-1:0]        seq;
        logic [PAYLOAD_BITS-1:0] payload;
    } ring_rec_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_RD1,
        ST_CMP,
        ST_DELAY,
        ST_HEAD,
        ST_OUT
    } state_t;

endpackage

`default_nettype wire

[hdl/sijb_ring.sv]
// Record ring of the jitter buffer: a single-port synchronous memory with a
// registered read. Depends on sijb_pkg.
`default_nettype none

module sijb_ring
    import sijb_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [PTR_W-1:0] addr,
    input  wire ring_rec_t        wdata,
    output ring_rec_t             rdata
);

    ring_rec_t mem [RING_DEPTH];
    ring_rec_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[hdl/sijb_delay.sv]
// Delay tracker of the jitter buffer: a five-stage pipeline that smooths the
// total delay estimate with rounding and saturation. Depends on sijb_pkg.
`default_nettype none

module sijb_delay
    import sijb_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire logic [PTR_W-1:0]    cnt_m1,
    input  wire logic [SEQ_W-1:0]    target,
    input  wire logic [LINK_W-1:0]   link_delay,
    input  wire logic [TICK_W-1:0]   tick_period,
    input  wire logic [DELAY_W-1:0]  smoothed,
    output logic                     done,
    output logic [DELAY_W-1:0]       result
);

    localparam int M1_W  = PTR_W + SEQ_W;
    localparam int M2_W  = M1_W + TICK_W;
    localparam int X_W   = ((M2_W > LINK_W) ? M2_W : LINK_W) + 1;
    localparam int PA_W  = 16 + DELAY_W;
    localparam int PB_W  = 10 + X_W;
    localparam int SUM_W = ((PA_W > PB_W) ? PA_W : PB_W) + 1;
    localparam int SH_W  = SUM_W - 16;

    logic [M1_W-1:0]    m1_reg;
    logic [M2_W-1:0]    m2_reg;
    logic [X_W-1:0]     x_reg;
    logic [PA_W-1:0]    pa_reg;
    logic [PB_W-1:0]    pb_reg;
    logic [DELAY_W-1:0] result_reg;
    logic [3:0]         valid_reg;
    logic               done_reg;

    logic [SUM_W-1:0]   sum;
    logic [SH_W-1:0]    shifted;
    logic [DELAY_W-1:0] result_next;

    always_comb
    begin
        sum = SUM_W'(pa_reg) + SUM_W'(pb_reg) + SUM_W'(ROUND_HALF);
        shifted = sum[SUM_W-1:16];
        if (|shifted[SH_W-1:DELAY_W])
        begin
            result_next = DELAY_MAX;
        end
        else
        begin
            result_next = shifted[DELAY_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        m1_reg     <= M1_W'(cnt_m1) * M1_W'(target);
        m2_reg     <= M2_W'(m1_reg) * M2_W'(tick_period);
        x_reg      <= X_W'(link_delay) + X_W'(m2_reg);
        pa_reg     <= PA_W'(ALPHA_KEEP) * PA_W'(smoothed);
        pb_reg     <= PB_W'(ALPHA_NUM) * PB_W'(x_reg);
        result_reg <= result_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= {valid_reg[2:0], start};
            done_reg  <= valid_reg[3];
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

[hdl/sequenced_input_jitter_buffer.sv]
// Sequenced input jitter buffer, top level. From accept to the result strobe,
// enqueue, flush, overflow and short ticks pass EXEC and HEAD; a popping tick
// passes EXEC, RD1, CMP and HEAD; one that updates the delay estimate passes
// EXEC, RD1, CMP, DELAY and HEAD. The next item is taken in the strobe cycle;
// the single ring port and the delay multiply pipeline set the beat length.
// Asynchronous active-low reset empties the buffer and restores the registers.
`default_nettype none

module sequenced_input_jitter_buffer
    import sijb_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    start,
    output logic                         busy,
    input  wire logic [CMD_W-1:0]        cmd,
    input  wire logic [SEQ_W-1:0]        seq,
    input  wire logic [PAYLOAD_BITS-1:0] payload,
    output logic                         done,
    output logic                         accepted,
    output logic                         apply_new,
    output logic [SEQ_W-1:0]             apply_seq,
    output logic [PAYLOAD_BITS-1:0]      apply_payload,
    output logic                         overflow,
    output logic [DELAY_W-1:0]           total_delay_us,
    output logic [CNT_W-1:0]             occupancy,
    input  wire logic                    psel,
    input  wire logic                    penable,
    input  wire logic                    pwrite,
    input  wire logic [APB_ADDR_W-1:0]   paddr,
    input  wire logic [APB_DATA_W-1:0]   pwdata,
    output logic [APB_DATA_W-1:0]        prdata,
    output logic                         pready
);

    state_t state_reg, state_next;

    logic [CMD_W-1:0]        cmd_reg, cmd_next;
    logic [SEQ_W-1:0]        seq_reg, seq_next;
    logic [PAYLOAD_BITS-1:0] pay_reg, pay_next;
    logic [PTR_W-1:0]        head_reg, head_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic [SEQ_W-1:0]        newest_reg, newest_next;
    logic [STEP_W-1:0]       step_reg, step_next;
    logic [DELAY_W-1:0]      sd_reg, sd_next;
    logic                    ovf_flag_reg, ovf_flag_next;
    logic                    accepted_reg, accepted_next;
    logic                    apply_new_reg, apply_new_next;
    logic                    ovf_out_reg, ovf_out_next;
    logic [SEQ_W-1:0]        seq0_reg, seq0_next;

    logic [MAXOCC_W-1:0]     maxocc_reg;
    logic [LINK_W-1:0]       link_reg;
    logic [TICK_W-1:0]       tick_reg;

    logic                    mem_we;
    logic [PTR_W-1:0]        mem_addr;
    ring_rec_t               mem_wdata;
    ring_rec_t               mem_rdata;

    logic                    dly_start;
    logic                    dly_done;
    logic [DELAY_W-1:0]      dly_result;

    logic                    take;
    logic                    cfg_write;
    logic [SEQ_W-1:0]        seq_diff;
    logic                    stale;
    logic [SEQ_W-1:0]        target;
    logic [STEP_W-1:0]       step_inc;

    sijb_ring u_ring
    (
        .clk   (clk),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    sijb_delay u_delay
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (dly_start),
        .cnt_m1      (PTR_W'(count_reg - CNT_W'(1))),
        .target      (target),
        .link_delay  (link_reg),
        .tick_period (tick_reg),
        .smoothed    (sd_reg),
        .done        (dly_done),
        .result      (dly_result)
    );

    assign busy      = (state_reg != ST_IDLE) && (state_reg != ST_OUT);
    assign take      = start && !busy;
    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;

    always_comb
    begin
        case (paddr[3:2])
            REG_MAX_OCC:  prdata = APB_DATA_W'(maxocc_reg);
            REG_LINK_DLY: prdata = APB_DATA_W'(link_reg);
            REG_TICK_PER: prdata = APB_DATA_W'(tick_reg);
            default:      prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            maxocc_reg <= MAXOCC_RESET;
            link_reg   <= LINK_RESET;
            tick_reg   <= TICK_RESET;
        end
        else if (cfg_write)
        begin
            case (paddr[3:2])
                REG_MAX_OCC:  maxocc_reg <= pwdata[MAXOCC_W-1:0];
                REG_LINK_DLY: link_reg   <= pwdata[LINK_W-1:0];
                REG_TICK_PER: tick_reg   <= pwdata[TICK_W-1:0];
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        seq_diff = seq_reg - newest_reg;
        stale    = (count_reg != '0) && ((seq_diff == '0) || seq_diff[SEQ_W-1]);
        target   = mem_rdata.seq - seq0_reg;
        step_inc = (step_reg == STEP_MAX) ? step_reg : step_reg + STEP_W'(1);
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        seq_next       = seq_reg;
        pay_next       = pay_reg;
        head_next      = head_reg;
        count_next     = count_reg;
        newest_next    = newest_reg;
        step_next      = step_reg;
        sd_next        = sd_reg;
        ovf_flag_next  = ovf_flag_reg;
        accepted_next  = accepted_reg;
        apply_new_next = apply_new_reg;
        ovf_out_next   = ovf_out_reg;
        seq0_next      = seq0_reg;
        mem_we         = 1'b0;
        mem_addr       = head_reg;
        mem_wdata      = '{seq: seq_reg, payload: pay_reg};
        dly_start      = 1'b0;

        case (state_reg)
            ST_IDLE, ST_OUT:
            begin
                if (take)
                begin
                    cmd_next       = cmd;
                    seq_next       = seq;
                    pay_next       = payload;
                    accepted_next  = 1'b0;
                    apply_new_next = 1'b0;
                    ovf_out_next   = 1'b0;
                    state_next     = ST_EXEC;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_HEAD;
                case (cmd_reg)
                    CMD_ENQUEUE:
                    begin
                        mem_addr = head_reg + count_reg[PTR_W-1:0];
                        if (!stale && (count_reg < CNT_W'(RING_DEPTH)))
                        begin
                            mem_we        = 1'b1;
                            count_next    = count_reg + CNT_W'(1);
                            newest_next   = seq_reg;
                            accepted_next = 1'b1;
                        end
                    end
                    CMD_TICK:
                    begin
                        step_next = step_inc;
                        if (count_reg > CNT_W'(maxocc_reg))
                        begin
                            head_next      = head_reg + count_reg[PTR_W-1:0] - PTR_W'(1);
                            count_next     = CNT_W'(1);
                            step_next      = '0;
                            ovf_flag_next  = 1'b1;
                            ovf_out_next   = 1'b1;
                            apply_new_next = 1'b1;
                        end
                        else
                        begin
                            ovf_flag_next = 1'b0;
                            if (count_reg > CNT_W'(1))
                            begin
                                state_next = ST_RD1;
                            end
                        end
                    end
                    CMD_FLUSH:
                    begin
                        count_next = '0;
                        step_next  = '0;
                    end
                    default:
                    begin
                    end
                endcase
            end
            ST_RD1:
            begin
                mem_addr   = head_reg + PTR_W'(1);
                seq0_next  = mem_rdata.seq;
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                if (step_reg >= target)
                begin
                    head_next      = head_reg + PTR_W'(1);
                    count_next     = count_reg - CNT_W'(1);
                    step_next      = '0;
                    apply_new_next = 1'b1;
                    state_next     = ST_HEAD;
                end
                else
                begin
                    dly_start  = 1'b1;
                    state_next = ST_DELAY;
                end
            end
            ST_DELAY:
            begin
                if (dly_done)
                begin
                    sd_next    = dly_result;
                    state_next = ST_HEAD;
                end
            end
            ST_HEAD:
            begin
                state_next = ST_OUT;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            newest_reg    <= '0;
            step_reg      <= '0;
            sd_reg        <= DELAY_RESET;
            ovf_flag_reg  <= 1'b0;
            accepted_reg  <= 1'b0;
            apply_new_reg <= 1'b0;
            ovf_out_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            newest_reg    <= newest_next;
            step_reg      <= step_next;
            sd_reg        <= sd_next;
            ovf_flag_reg  <= ovf_flag_next;
            accepted_reg  <= accepted_next;
            apply_new_reg <= apply_new_next;
            ovf_out_reg   <= ovf_out_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg  <= cmd_next;
        seq_reg  <= seq_next;
        pay_reg  <= pay_next;
        seq0_reg <= seq0_next;
    end

    assign done           = (state_reg == ST_OUT);
    assign accepted       = accepted_reg;
    assign apply_new      = apply_new_reg;
    assign overflow       = ovf_out_reg;
    assign total_delay_us = sd_reg;
    assign occupancy      = count_reg;
    assign apply_seq      = (count_reg != '0) ? mem_rdata.seq : '0;
    assign apply_payload  = (count_reg != '0) ? mem_rdata.payload : '0;

    a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
        take |=> !done)
        else $error("result strobe in the cycle after an accepted beat");

    a_accept_is_enqueue: assert property (@(posedge clk) disable iff (!rst_n)
        (done && accepted) |-> ((cmd_reg == CMD_ENQUEUE) && (occupancy != '0)))
        else $error("stored flag without an enqueue into a non-empty ring");

    a_overflow_keeps_one: assert property (@(posedge clk) disable iff (!rst_n)
        (done && overflow) |-> (apply_new && (occupancy == CNT_W'(1))))
        else $error("overflow did not leave exactly the newest entry");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        $past(count_reg == CNT_W'(RING_DEPTH)) |-> (count_reg <= CNT_W'(RING_DEPTH)))
        else $error("ring occupancy beyond its depth");

endmodule

`default_nettype wire

[tb/sv/testbench.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the sequenced input jitter buffer: a stimulus table,
// then shaped random beats under several register settings, each result checked.
// Depends on sijb_pkg and the sequenced_input_jitter_buffer top level.

module testbench;
    import sijb_pkg::*;

    localparam logic [CMD_W-1:0] CMD_NOP = 2'd3;
    localparam int STALL_LIMIT = 2000;
    localparam int PHASES = 7;

    typedef struct packed {
        logic                    accepted;
        logic                    apply_new;
        logic [SEQ_W-1:0]        apply_seq;
        logic [PAYLOAD_BITS-1:0] apply_payload;
        logic                    overflow;
        logic [DELAY_W-1:0]      delay_est;
        logic [CNT_W-1:0]        occupancy;
    } status_t;

    typedef struct packed {
        logic [CMD_W-1:0]        op;
        logic [SEQ_W-1:0]        sq;
        logic [PAYLOAD_BITS-1:0] data;
        logic                    typed;
        status_t                 want;
    } beat_row_t;

    typedef enum int {
        SEG_STREAM,
        SEG_STALE,
        SEG_NOISE,
        SEG_TICKS,
        SEG_FILL,
        SEG_STORM
    } segment_t;

    logic                    clk;
    logic                    rst_n;
    logic                    start;
    logic                    busy;
    logic [CMD_W-1:0]        cmd;
    logic [SEQ_W-1:0]        seq;
    logic [PAYLOAD_BITS-1:0] payload;
    logic                    done;
    logic                    accepted;
    logic                    apply_new;
    logic [SEQ_W-1:0]        apply_seq;
    logic [PAYLOAD_BITS-1:0] apply_payload;
    logic                    overflow;
    logic [DELAY_W-1:0]      total_delay_us;
    logic [CNT_W-1:0]        occupancy;
    logic                    psel;
    logic                    penable;
    logic                    pwrite;
    logic [APB_ADDR_W-1:0]   paddr;
    logic [APB_DATA_W-1:0]   pwdata;
    logic [APB_DATA_W-1:0]   prdata;
    logic                    pready;

    // Mirror of the buffer state and its registers.
    logic [SEQ_W-1:0]        ring_seq [RING_DEPTH];
    logic [PAYLOAD_BITS-1:0] ring_data [RING_DEPTH];
    int unsigned             head_slot = 0;
    int unsigned             fill = 0;
    int unsigned             steps = 0;
    logic [SEQ_W-1:0]        last_seq = '0;
    logic [DELAY_W-1:0]      smooth_us = DELAY_RESET;
    logic                    cut_flag = 1'b0;
    int unsigned             occ_limit = MAXOCC_RESET;
    int unsigned             link_us = LINK_RESET;
    int unsigned             tick_us = TICK_RESET;

    status_t pending [int];
    int      pend_wr = 0;
    int      pend_rd = 0;
    int      faults = 0;
    int      results_seen = 0;
    int      beats_done = 0;
    int      idle_pct = 12;
    int      stall_cycles = 0;
    int      drops = 0;
    int      cuts = 0;
    int      pops = 0;
    int      delay_updates = 0;
    int      clips = 0;
    int      settings_used = 0;

    beat_row_t steer_rows [22] = '{
        '{CMD_TICK,    8'h00, 32'h0000_0000, 1'b1,
          '{1'b0, 1'b0, 8'h00, 32'h0, 1'b0, DELAY_RESET, 7'd0}},
        '{CMD_ENQUEUE, 8'h00, 32'h0000_0000, 1'b1,
          '{1'b1, 1'b0, 8'h00, 32'h0, 1'b0, DELAY_RESET, 7'd1}},
        '{CMD_ENQUEUE, 8'h00, 32'hFFFF_FFFF, 1'b1,
          '{1'b0, 1'b0, 8'h00, 32'h0, 1'b0, DELAY_RESET, 7'd1}},
        '{CMD_ENQUEUE, 8'h80, 32'hFFFF_FFFF, 1'b1,
          '{1'b0, 1'b0, 8'h00, 32'h0, 1'b0, DELAY_RESET, 7'd1}},
        '{CMD_ENQUEUE, 8'h7F, 32'hFFFF_FFFF, 1'b1,
          '{1'b1, 1'b0, 8'h00, 32'h0, 1'b0, DELAY_RESET, 7'd2}},
        '{CMD_ENQUEUE, 8'hFF, 32'h0000_0000, 1'b1,
          '{1'b0, 1'b0, 8'h00, 32'h0, 1'b0, DELAY_RESET, 7'd2}},
        '{CMD_TICK,    8'h00, 32'h0000_0000, 1'b0, '0},
        '{CMD_NOP,     8'h3C, 32'h1234_5678, 1'b0, '0},
        '{CMD_ENQUEUE, 8'h80, 32'h0000_0001, 1'b0, '0},
        '{CMD_TICK,    8'h00, 32'h0000_0000, 1'b0, '0},
        '{CMD_TICK,    8'hFF, 32'hFFFF_FFFF, 1'b0, '0},
        '{CMD_FLUSH,   8'h00, 32'h0000_0000, 1'b0, '0},
        '{CMD_ENQUEUE, 8'h80, 32'h8000_0000, 1'b0, '0},
        '{CMD_ENQUEUE, 8'h81, 32'h7FFF_FFFF, 1'b0, '0},
        '{CMD_TICK,    8'h00, 32'h0000_0000, 1'b0, '0},
        '{CMD_ENQUEUE, 8'h83, 32'hA5A5_A5A5, 1'b0, '0},
        '{CMD_TICK,    8'h00, 32'h0000_0000, 1'b0, '0},
        '{CMD_TICK,    8'h00, 32'h0000_0000, 1'b0, '0},
        '{CMD_TICK,    8'h00, 32'h0000_0000, 1'b0, '0},
        '{CMD_NOP,     8'hFF, 32'hFFFF_FFFF, 1'b0, '0},
        '{CMD_FLUSH,   8'hFF, 32'hFFFF_FFFF, 1'b0, '0},
        '{CMD_FLUSH,   8'h00, 32'h0000_0000, 1'b0, '0}
    };

    int unsigned occ_plan  [PHASES] = '{16, 63, 1, 16, 16, 8, 16};
    int unsigned link_plan [PHASES] = '{0, 1000000, 0, 250000, 0, 1000000, 0};
    int unsigned tick_plan [PHASES] = '{16667, 100000, 1, 20000, 16667, 100000, 16667};
    bit          roll_plan [PHASES] = '{0, 0, 0, 0, 1, 0, 1};

    sequenced_input_jitter_buffer dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .cmd           (cmd),
        .seq           (seq),
        .payload       (payload),
        .done          (done),
        .accepted      (accepted),
        .apply_new     (apply_new),
        .apply_seq     (apply_seq),
        .apply_payload (apply_payload),
        .overflow      (overflow),
        .total_delay_us(total_delay_us),
        .occupancy     (occupancy),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic status_t advance_buffer(input logic [CMD_W-1:0] op,
                                               input logic [SEQ_W-1:0] sq,
                                               input logic [PAYLOAD_BITS-1:0] data);
        status_t         r;
        logic [SEQ_W-1:0] gap;
        logic [SEQ_W-1:0] target;
        int unsigned      slot;
        longint unsigned  lag;
        longint unsigned  acc;
        r = '0;
        case (op)
            CMD_ENQUEUE:
            begin
                gap = sq - last_seq;
                if (!(fill != 0 && (gap == '0 || gap[SEQ_W-1])) && fill < RING_DEPTH)
                begin
                    slot = (head_slot + fill) % RING_DEPTH;
                    ring_seq[slot] = sq;
                    ring_data[slot] = data;
                    fill++;
                    last_seq = sq;
                    r.accepted = 1'b1;
                end
                else
                begin
                    drops++;
                end
            end
            CMD_TICK:
            begin
                if (steps < STEP_MAX)
                    steps++;
                if (fill > occ_limit)
                begin
                    head_slot = (head_slot + fill - 1) % RING_DEPTH;
                    fill = 1;
                    steps = 0;
                    cut_flag = 1'b1;
                    r.apply_new = 1'b1;
                    cuts++;
                end
                else
                begin
                    cut_flag = 1'b0;
                    if (fill > 1)
                    begin
                        target = ring_seq[(head_slot + 1) % RING_DEPTH] - ring_seq[head_slot];
                        if (steps >= target)
                        begin
                            head_slot = (head_slot + 1) % RING_DEPTH;
                            fill--;
                            steps = 0;
                            r.apply_new = 1'b1;
                            pops++;
                        end
                        else
                        begin
                            lag = 64'(link_us) + 64'(fill - 1) * 64'(target) * 64'(tick_us);
                            acc = 64'(ALPHA_KEEP) * 64'(smooth_us) + 64'(ALPHA_NUM) * lag
                                  + 64'(ROUND_HALF);
                            acc = acc >> 16;
                            delay_updates++;
                            if (acc > 64'(DELAY_MAX))
                            begin
                                smooth_us = DELAY_MAX;
                                clips++;
                            end
                            else
                            begin
                                smooth_us = DELAY_W'(acc);
                            end
                        end
                    end
                end
                r.overflow = cut_flag;
            end
            CMD_FLUSH:
            begin
                fill = 0;
                steps = 0;
            end
            default: ;
        endcase
        if (fill != 0)
        begin
            r.apply_seq = ring_seq[head_slot];
            r.apply_payload = ring_data[head_slot];
        end
        r.delay_est = smooth_us;
        r.occupancy = CNT_W'(fill);
        return r;
    endfunction

    function automatic logic [SEQ_W-1:0] next_seq();
        int unsigned step;
        step = ($urandom_range(9) == 0) ? $urandom_range(127, 1) : $urandom_range(4, 1);
        return last_seq + SEQ_W'(step);
    endfunction

    function automatic logic [PAYLOAD_BITS-1:0] pick_payload();
        int unsigned roll;
        roll = $urandom_range(9);
        if (roll == 0)
            return '0;
        else if (roll == 1)
            return '1;
        return PAYLOAD_BITS'($urandom);
    endfunction

    task automatic note_fault(input string what, input longint unsigned want_v,
                              input longint unsigned got_v);
        faults++;
        if (faults <= 10)
            $display("Mismatch on result %0d, %s: expected %0h, got %0h",
                     results_seen, what, want_v, got_v);
    endtask

    task automatic compare_field(input string what, input longint unsigned want_v,
                                 input longint unsigned got_v);
        if (want_v != got_v)
            note_fault(what, want_v, got_v);
    endtask

    always @(posedge clk)
    begin
        status_t got;
        status_t want;
        if (rst_n && done)
        begin
            got = '{accepted, apply_new, apply_seq, apply_payload, overflow,
                    total_delay_us, occupancy};
            results_seen++;
            if (pending.size() == 0)
            begin
                note_fault("beat with nothing pending", 0, 0);
            end
            else
            begin
                want = pending[pend_rd];
                pending.delete(pend_rd);
                pend_rd++;
                compare_field("accepted", want.accepted, got.accepted);
                compare_field("apply_new", want.apply_new, got.apply_new);
                compare_field("apply_seq", want.apply_seq, got.apply_seq);
                compare_field("apply_payload", want.apply_payload, got.apply_payload);
                compare_field("overflow", want.overflow, got.overflow);
                compare_field("total_delay_us", want.delay_est, got.delay_est);
                compare_field("occupancy", want.occupancy, got.occupancy);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done)
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("Watchdog: no beat for %0d cycles, %0d results outstanding",
                         stall_cycles, pending.size());
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    task automatic issue_beat(input logic [CMD_W-1:0] op, input logic [SEQ_W-1:0] sq,
                              input logic [PAYLOAD_BITS-1:0] data,
                              input bit typed = 1'b0, input status_t want = '0);
        status_t model_out;
        if ($urandom_range(199) == 0)
        begin
            @(negedge clk);
            start <= 1'b0;
            while (pending.size() != 0)
                @(posedge clk);
        end
        while ($urandom_range(99) < idle_pct)
        begin
            @(negedge clk);
            start <= 1'b0;
            @(posedge clk);
        end
        @(negedge clk);
        start <= 1'b1;
        cmd <= op;
        seq <= sq;
        payload <= data;
        do
            @(posedge clk);
        while (busy);
        model_out = advance_buffer(op, sq, data);
        pending[pend_wr] = typed ? want : model_out;
        pend_wr++;
        if (op != CMD_NOP)
            beats_done++;
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [APB_DATA_W-1:0] value);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        case (idx)
            REG_MAX_OCC:  occ_limit = value[MAXOCC_W-1:0];
            REG_LINK_DLY: link_us = value[LINK_W-1:0];
            REG_TICK_PER: tick_us = value[TICK_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic settle();
        @(negedge clk);
        start <= 1'b0;
        while (pending.size() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    task automatic run_segment(input segment_t kind);
        int n;
        int roll;
        n = $urandom_range(20, 6);
        case (kind)
            SEG_STREAM:
            begin
                repeat (n)
                begin
                    roll = $urandom_range(99);
                    if (roll < 55)
                        issue_beat(CMD_ENQUEUE, next_seq(), pick_payload());
                    else if (roll < 95)
                        issue_beat(CMD_TICK, SEQ_W'($urandom), pick_payload());
                    else if (roll < 98)
                        issue_beat(CMD_FLUSH, SEQ_W'($urandom), pick_payload());
                    else
                        issue_beat(CMD_NOP, SEQ_W'($urandom), pick_payload());
                end
            end
            SEG_STALE:
            begin
                repeat (n)
                begin
                    roll = $urandom_range(99);
                    if (roll < 50)
                        issue_beat(CMD_ENQUEUE, last_seq - SEQ_W'($urandom_range(128, 0)),
                                   pick_payload());
                    else if (roll < 80)
                        issue_beat(CMD_ENQUEUE, next_seq(), pick_payload());
                    else
                        issue_beat(CMD_TICK, SEQ_W'($urandom), pick_payload());
                end
            end
            SEG_NOISE:
            begin
                repeat (n)
                    issue_beat(CMD_W'($urandom_range(3, 0)), SEQ_W'($urandom),
                               PAYLOAD_BITS'($urandom));
            end
            SEG_TICKS:
            begin
                repeat ($urandom_range(30, 5))
                    issue_beat(CMD_TICK, SEQ_W'($urandom), PAYLOAD_BITS'($urandom));
            end
            SEG_FILL:
            begin
                // Fill the ring past its depth, then let the overflow cut it back.
                issue_beat(CMD_FLUSH, SEQ_W'($urandom), pick_payload());
                repeat (RING_DEPTH + 2)
                    issue_beat(CMD_ENQUEUE, last_seq + 8'd1, pick_payload());
                repeat (2)
                    issue_beat(CMD_TICK, SEQ_W'($urandom), pick_payload());
            end
            SEG_STORM:
            begin
                // A lone entry lets the step counter reach its ceiling before a wide gap.
                issue_beat(CMD_FLUSH, SEQ_W'($urandom), pick_payload());
                issue_beat(CMD_ENQUEUE, next_seq(), pick_payload());
                repeat ($urandom_range(270, 258))
                    issue_beat(CMD_TICK, SEQ_W'($urandom), pick_payload());
                issue_beat(CMD_ENQUEUE, last_seq + 8'd127, pick_payload());
                repeat (2)
                    issue_beat(CMD_TICK, SEQ_W'($urandom), pick_payload());
            end
            default: ;
        endcase
    endtask

    initial
    begin
        int quota;
        int roll;
        rst_n = 1'b0;
        start = 1'b0;
        cmd = CMD_NOP;
        seq = '0;
        payload = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        write_reg(REG_MAX_OCC, 32'd2);
        settings_used++;
        foreach (steer_rows[i])
            issue_beat(steer_rows[i].op, steer_rows[i].sq, steer_rows[i].data,
                       steer_rows[i].typed, steer_rows[i].want);

        for (int ph = 0; ph < PHASES; ph++)
        begin
            settle();
            if (roll_plan[ph])
            begin
                occ_plan[ph] = $urandom_range(63, 1);
                link_plan[ph] = $urandom_range(1000000, 0);
                tick_plan[ph] = $urandom_range(100000, 1);
            end
            write_reg(REG_MAX_OCC, occ_plan[ph]);
            write_reg(REG_LINK_DLY, link_plan[ph]);
            write_reg(REG_TICK_PER, tick_plan[ph]);
            settings_used++;
            idle_pct = (ph == 4) ? 0 : 12;
            quota = beats_done + 30;
            if (ph == 1)
                run_segment(SEG_FILL);
            if (ph == 3)
                run_segment(SEG_STORM);
            while (beats_done < quota)
            begin
                roll = $urandom_range(99);
                if (roll < 60)
                    run_segment(SEG_STREAM);
                else if (roll < 75)
                    run_segment(SEG_STALE);
                else if (roll < 85)
                    run_segment(SEG_NOISE);
                else
                    run_segment(SEG_TICKS);
            end
        end
        settle();

        $display("Covered %0d beats and %0d results over %0d register settings.",
                 beats_done, results_seen, settings_used);
        $display("Saw %0d dropped records, %0d overflow cuts, %0d head pops,",
                 drops, cuts, pops);
        $display("and %0d delay updates of which %0d clipped.", delay_updates, clips);
        if (faults == 0 && pending.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
